>>> src/aair_pkg.sv
// ----------------------------------------------------------------------------
// aair_pkg
// Shared types and constants of the area-average resampler.
// ----------------------------------------------------------------------------
package aair_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam int unsigned AW        = XW + YW;
  localparam int unsigned SzW       = 9;
  localparam int unsigned PosW      = 17;  // 9-bit size times 8-bit index, plus one
  localparam int unsigned WW        = 18;  // product of two 9-bit overlap lengths
  localparam int unsigned AccW      = 34;  // 8-bit value times area (<= 2^16), summed
  localparam int unsigned AreaW     = 17;

  localparam logic [1:0] RegSrcW = 2'd0;
  localparam logic [1:0] RegSrcH = 2'd1;
  localparam logic [1:0] RegDstW = 2'd2;
  localparam logic [1:0] RegDstH = 2'd3;

  typedef struct packed {
    logic [SzW-1:0] sw;
    logic [SzW-1:0] sh;
    logic [SzW-1:0] dw;
    logic [SzW-1:0] dh;
  } size_t;

  typedef struct packed {
    logic wr;        // store source pixel
    logic start;     // latch request coordinates
    logic div_x0;    // capture a finished quotient
    logic setup_y;   // load box bounds
    logic setup_x;   // load row and column walk
    logic rd;        // issue store read
    logic acc;       // accumulate returned pixel
    logic adv_x;
    logic adv_y;
    logic div_start;
    logic div_step;
    logic sel_y;     // bound divider works on y when high
    logic [1:0] bsel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic x_last;
    logic y_last;
  } dp_sts_t;

endpackage

>>> src/aair_if.sv
// ----------------------------------------------------------------------------
// aair_in_if / aair_out_if
// Valid/ready channels carrying input and result requests.
// ----------------------------------------------------------------------------
interface aair_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] in_alpha;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  modport source (output valid, func, pos_x, pos_y, in_alpha, in_blue, in_green, in_red,
                  input ready);
  modport sink   (input valid, func, pos_x, pos_y, in_alpha, in_blue, in_green, in_red,
                  output ready);
endinterface

interface aair_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  modport source (output valid, out_alpha, out_blue, out_green, out_red, input ready);
  modport sink   (input valid, out_alpha, out_blue, out_green, out_red, output ready);
endinterface

>>> src/aair_ram.sv
// ----------------------------------------------------------------------------
// aair_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module aair_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/aair_div.sv
// ----------------------------------------------------------------------------
// aair_div
// Restoring divider, one quotient bit per cycle while step_i is high.
// ----------------------------------------------------------------------------
module aair_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          step_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o,
  output logic          done_o
);
  logic [NW-1:0]          quo_q;
  logic [DW:0]            rem_q;
  logic [DW-1:0]          den_q;
  logic [$clog2(NW+1)-1:0] cnt_q;
  logic [DW:0]            trial;

  assign trial = {rem_q[DW-1:0], quo_q[NW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= ($clog2(NW+1))'(NW);
    end else if (step_i && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (step_i && cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = (cnt_q == '0);
endmodule

>>> src/aair_dp.sv
// ----------------------------------------------------------------------------
// aair_dp
// Datapath: bound computation, box walk, weighted accumulation, division.
// ----------------------------------------------------------------------------
module aair_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aair_pkg::size_t        size_i,
  input  aair_pkg::dp_cmd_t      cmd_i,
  output aair_pkg::dp_sts_t      sts_o,
  input  logic [7:0]             pos_x_i,
  input  logic [7:0]             pos_y_i,
  input  logic [31:0]            wdata_i,
  output logic [31:0]            result_o
);
  localparam int unsigned PW = aair_pkg::PosW;
  localparam int unsigned SW = aair_pkg::SzW;

  // effective sizes: zero -> 1, above maximum -> maximum
  function automatic logic [SW-1:0] eff(input logic [SW-1:0] v, input logic [SW-1:0] m);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) r = SW'(1);
    else if (v > m) r = m;
    return r;
  endfunction

  logic [SW-1:0] sw, sh, dw, dh;
  assign sw = eff(size_i.sw, SW'(aair_pkg::MaxWidth));
  assign sh = eff(size_i.sh, SW'(aair_pkg::MaxHeight));
  assign dw = eff(size_i.dw, SW'(aair_pkg::MaxWidth));
  assign dh = eff(size_i.dh, SW'(aair_pkg::MaxHeight));

  logic [SW-1:0] tx_q, ty_q;
  logic [PW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [SW-1:0] sx0_q, sx1_q, sy0_q, sy1_q;
  logic [SW-1:0] sx_q, sy_q;
  logic [PW-1:0] cx0_q, cy0_q;   // sx*dw, sy*dh
  logic [aair_pkg::WW-1:0] w_q;
  logic [aair_pkg::AccW-1:0] acc_q [4];
  logic [1:0] ch_q;
  logic [7:0] res_q [4];

  // bound division operands for the shared divider: bound over dw/dh
  logic [PW-1:0] bnum;
  logic [SW-1:0] bden;
  logic [PW-1:0] bquo;
  always_comb begin
    bden = cmd_i.sel_y ? dh : dw;
    case (cmd_i.bsel[0])
      1'b0:    bnum = cmd_i.sel_y ? y0_q : x0_q;
      default: bnum = (cmd_i.sel_y ? y1_q : x1_q) + PW'(bden) - PW'(1);
    endcase
  end

  // one divider shared for bounds and final quotient
  logic [aair_pkg::AccW-1:0] dnum, dquo;
  logic [aair_pkg::AreaW-1:0] dden;
  logic                      dstart, dstep;
  logic                      fin_q;  // divider in final-quotient mode
  assign dnum   = fin_q ? acc_q[ch_q] : aair_pkg::AccW'(bnum);
  assign dden   = fin_q ? aair_pkg::AreaW'(sw) * aair_pkg::AreaW'(sh)
                        : aair_pkg::AreaW'(bden);
  assign dstart = cmd_i.div_start;
  assign dstep  = cmd_i.div_step;
  assign bquo   = dquo[PW-1:0];

  aair_div #(.NW(aair_pkg::AccW), .DW(aair_pkg::AreaW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .step_i(dstep),
    .num_i(dnum), .den_i(dden), .quo_o(dquo), .done_o(sts_o.div_done)
  );

  // overlap of [a0,a1) with [b0,b0+d)
  function automatic logic [SW-1:0] ovl(input logic [PW-1:0] a0, input logic [PW-1:0] a1,
                                       input logic [PW-1:0] b0, input logic [SW-1:0] d);
    logic [PW-1:0] b1, lo, hi;
    b1 = b0 + PW'(d);
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? SW'(hi - lo) : '0;
  endfunction

  logic [aair_pkg::AW-1:0] addr;
  logic [31:0]             rdata;
  assign addr = cmd_i.wr ? {pos_y_i, pos_x_i} : {sy_q[7:0], sx_q[7:0]};

  aair_ram #(.Width(32), .Depth(aair_pkg::MaxWidth * aair_pkg::MaxHeight)) u_ram (
    .clk_i, .we_i(cmd_i.wr), .re_i(cmd_i.rd), .addr_i(addr),
    .wdata_i(wdata_i), .rdata_o(rdata)
  );

  logic [SW-1:0] sx_n, sy_n;
  assign sx_n = sx_q + 1'b1;
  assign sy_n = sy_q + 1'b1;
  assign sts_o.x_last = (sx_n >= sx1_q) || (sx_n >= sw);
  assign sts_o.y_last = (sy_n >= sy1_q) || (sy_n >= sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
      ch_q  <= '0;
    end else begin
      if (cmd_i.start) begin
        fin_q <= 1'b0;
        ch_q  <= '0;
      end else if (cmd_i.setup_x) begin
        // all four bounds are in; the divider now serves the channel quotients
        fin_q <= 1'b1;
      end
      if (fin_q && cmd_i.div_x0) begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      tx_q <= (SW'(pos_x_i) < dw) ? SW'(pos_x_i) : dw - 1'b1;
      ty_q <= (SW'(pos_y_i) < dh) ? SW'(pos_y_i) : dh - 1'b1;
      for (int c = 0; c < 4; c++) acc_q[c] <= '0;
    end
    if (cmd_i.setup_y && !fin_q) begin
      x0_q <= PW'(tx_q) * PW'(sw);
      x1_q <= PW'(tx_q) * PW'(sw) + PW'(sw);
      y0_q <= PW'(ty_q) * PW'(sh);
      y1_q <= PW'(ty_q) * PW'(sh) + PW'(sh);
    end
    // capture bound quotients
    if (cmd_i.div_x0 && !fin_q) begin
      case ({cmd_i.sel_y, cmd_i.bsel[0]})
        2'b00:   sx0_q <= SW'(bquo);
        2'b01:   sx1_q <= SW'(bquo);
        2'b10:   sy0_q <= SW'(bquo);
        default: sy1_q <= SW'(bquo);
      endcase
    end
    if (cmd_i.div_x0 && fin_q) begin
      res_q[ch_q] <= dquo[7:0];
    end
    if (cmd_i.setup_x) begin
      sy_q  <= sy0_q;
      cy0_q <= PW'(sy0_q) * PW'(dh);
    end
    if (cmd_i.adv_y) begin
      sy_q  <= sy_n;
      cy0_q <= cy0_q + PW'(dh);
    end
    if (cmd_i.setup_x || cmd_i.adv_y) begin
      sx_q  <= sx0_q;
      cx0_q <= PW'(sx0_q) * PW'(dw);
    end else if (cmd_i.adv_x) begin
      sx_q  <= sx_n;
      cx0_q <= cx0_q + PW'(dw);
    end
    if (cmd_i.rd) begin
      w_q <= aair_pkg::WW'(ovl(y0_q, y1_q, cy0_q, dh)) *
             aair_pkg::WW'(ovl(x0_q, x1_q, cx0_q, dw));
    end
    if (cmd_i.acc) begin
      for (int c = 0; c < 4; c++) begin
        acc_q[c] <= acc_q[c] + aair_pkg::AccW'(rdata[31-8*c -: 8]) * aair_pkg::AccW'(w_q);
      end
    end
  end

  assign result_o = {res_q[0], res_q[1], res_q[2], res_q[3]};
endmodule

>>> src/aair_ctrl.sv
// ----------------------------------------------------------------------------
// aair_ctrl
// Sequencer for writes, bound divisions, box walk and final division.
// ----------------------------------------------------------------------------
module aair_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  aair_pkg::dp_sts_t sts_i,
  output aair_pkg::dp_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_BSTART, S_BRUN, S_WALK, S_RD, S_WAIT, S_ACC,
    S_FSTART, S_FRUN, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] b_q;   // bound index / channel
  logic       last_x_q, last_y_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o       = '0;
    cmd_o.bsel  = b_q;
    cmd_o.sel_y = b_q[1];
    case (state_q)
      S_IDLE: begin
        cmd_o.wr    = in_valid_i && !in_func_i;
        cmd_o.start = in_valid_i && in_func_i;
      end
      S_POS:    cmd_o.setup_y   = 1'b1;
      S_BSTART: cmd_o.div_start = 1'b1;
      S_BRUN: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.div_x0   = sts_i.div_done;
      end
      S_WALK:   cmd_o.setup_x = 1'b1;
      S_RD:     cmd_o.rd      = 1'b1;
      S_ACC: begin
        cmd_o.acc   = 1'b1;
        cmd_o.adv_x = !last_x_q;
        cmd_o.adv_y = last_x_q && !last_y_q;
      end
      S_FSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.bsel      = 2'd3;
        cmd_o.sel_y     = 1'b1;
      end
      S_FRUN: begin
        cmd_o.div_step = !sts_i.div_done;
        cmd_o.div_x0   = sts_i.div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      b_q      <= '0;
      last_x_q <= 1'b0;
      last_y_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i && in_func_i) begin
          b_q     <= '0;
          state_q <= S_POS;
        end
        S_POS:    state_q <= S_BSTART;
        S_BSTART: state_q <= S_BRUN;
        S_BRUN: if (sts_i.div_done) begin
          b_q     <= b_q + 1'b1;
          state_q <= (b_q == 2'd3) ? S_WALK : S_BSTART;
        end
        S_WALK:   state_q <= S_RD;
        S_RD: begin
          last_x_q <= sts_i.x_last;
          last_y_q <= sts_i.y_last;
          state_q  <= S_WAIT;
        end
        S_WAIT:   state_q <= S_ACC;
        S_ACC: begin
          b_q     <= '0;
          state_q <= (last_x_q && last_y_q) ? S_FSTART : S_RD;
        end
        S_FSTART: state_q <= S_FRUN;
        S_FRUN: if (sts_i.div_done) begin
          b_q     <= b_q + 1'b1;
          state_q <= (b_q == 2'd3) ? S_OUT : S_FSTART;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/area_average_image_resampler_core.sv
// ----------------------------------------------------------------------------
// area_average_image_resampler_core
// Box-filter resampler over a 256x256 RGBA store.
// ----------------------------------------------------------------------------
// A write request stores one pixel. A target request first runs the divider for
// the four box bounds, then reads and accumulates each covered source pixel (single
// store read port), then forms the four channel quotients through one shared
// serial divider. One request in flight; result held until taken.
// Reset: sizes return to 256; the pixel store is not cleared.
module area_average_image_resampler_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  aair_in_if.sink           in_if,
  aair_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  aair_pkg::size_t   size_q;
  aair_pkg::dp_cmd_t cmd;
  aair_pkg::dp_sts_t sts;
  logic [31:0]       result;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= {4{9'd256}};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        aair_pkg::RegSrcW: size_q.sw <= pwdata[8:0];
        aair_pkg::RegSrcH: size_q.sh <= pwdata[8:0];
        aair_pkg::RegDstW: size_q.dw <= pwdata[8:0];
        default:           size_q.dh <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aair_pkg::RegSrcW: prdata = {23'd0, size_q.sw};
      aair_pkg::RegSrcH: prdata = {23'd0, size_q.sh};
      aair_pkg::RegDstW: prdata = {23'd0, size_q.dw};
      default:           prdata = {23'd0, size_q.dh};
    endcase
  end

  aair_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_func_i(in_if.func), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  aair_dp u_dp (
    .clk_i, .rst_ni, .size_i(size_q), .cmd_i(cmd), .sts_o(sts),
    .pos_x_i(in_if.pos_x), .pos_y_i(in_if.pos_y),
    .wdata_i({in_if.in_alpha, in_if.in_blue, in_if.in_green, in_if.in_red}),
    .result_o(result)
  );

  assign out_if.out_alpha = result[31:24];
  assign out_if.out_blue  = result[23:16];
  assign out_if.out_green = result[15:8];
  assign out_if.out_red   = result[7:0];
endmodule

>>> verif/resample_checker.sv
// ----------------------------------------------------------------------------
// resample_checker
// Watches the request channels and the register port of the area-average
// resampler. It keeps its own image copy and size registers, predicts the
// box-filtered pixel for every target request and compares each returned
// result, channel by channel, with the oldest prediction.
// ----------------------------------------------------------------------------
module resample_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  aair_in_if          in_mon,
  aair_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  rgba_t                    image_copy [aair_pkg::MaxWidth*aair_pkg::MaxHeight];
  logic [aair_pkg::SzW-1:0] src_w, src_h, dst_w, dst_h;
  rgba_t                    averages_due [$];

  function automatic longint unsigned clamp_size(logic [aair_pkg::SzW-1:0] v,
                                                 int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint unsigned span(longint unsigned a0, longint unsigned a1,
                                           longint unsigned b0, longint unsigned b1);
    longint unsigned lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Exact box average: weights in units of 1/dst, truncating divide by the area.
  function automatic rgba_t box_average(logic [7:0] px, logic [7:0] py);
    longint unsigned sw, sh, dw, dh, tx, ty, x0, x1, y0, y1;
    longint unsigned wy, w, area;
    longint unsigned sum_a, sum_b, sum_g, sum_r;
    rgba_t           pix, res;
    sw = clamp_size(src_w, aair_pkg::MaxWidth);
    sh = clamp_size(src_h, aair_pkg::MaxHeight);
    dw = clamp_size(dst_w, aair_pkg::MaxWidth);
    dh = clamp_size(dst_h, aair_pkg::MaxHeight);
    tx = (px < dw) ? px : dw - 1;
    ty = (py < dh) ? py : dh - 1;
    x0 = tx * sw;  x1 = (tx + 1) * sw;
    y0 = ty * sh;  y1 = (ty + 1) * sh;
    area  = sw * sh;
    sum_a = 0; sum_b = 0; sum_g = 0; sum_r = 0;
    for (longint unsigned sy = y0 / dh; sy < (y1 + dh - 1) / dh && sy < sh; sy++) begin
      wy = span(y0, y1, sy * dh, (sy + 1) * dh);
      for (longint unsigned sx = x0 / dw; sx < (x1 + dw - 1) / dw && sx < sw; sx++) begin
        w     = wy * span(x0, x1, sx * dw, (sx + 1) * dw);
        pix   = image_copy[sy * aair_pkg::MaxWidth + sx];
        sum_a += pix.alpha * w;
        sum_b += pix.blue * w;
        sum_g += pix.green * w;
        sum_r += pix.red * w;
      end
    end
    res.alpha = 8'(sum_a / area);
    res.blue  = 8'(sum_b / area);
    res.green = 8'(sum_g / area);
    res.red   = 8'(sum_r / area);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w <= 9'd256;
      src_h <= 9'd256;
      dst_w <= 9'd256;
      dst_h <= 9'd256;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        aair_pkg::RegSrcW: src_w <= pwdata[aair_pkg::SzW-1:0];
        aair_pkg::RegSrcH: src_h <= pwdata[aair_pkg::SzW-1:0];
        aair_pkg::RegDstW: dst_w <= pwdata[aair_pkg::SzW-1:0];
        aair_pkg::RegDstH: dst_h <= pwdata[aair_pkg::SzW-1:0];
        default: ;
      endcase
    end
  end

  initial fail_count = 0;
  assign pending = averages_due.size();

  always @(posedge clk_i) begin
    rgba_t want, got;
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      if (!in_mon.func)
        image_copy[{in_mon.pos_y, in_mon.pos_x}] =
          {in_mon.in_alpha, in_mon.in_blue, in_mon.in_green, in_mon.in_red};
      else
        averages_due.push_back(box_average(in_mon.pos_x, in_mon.pos_y));
    end
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      got = {out_mon.out_alpha, out_mon.out_blue, out_mon.out_green, out_mon.out_red};
      if (averages_due.size() == 0) begin
        $display("%0t: result with no request outstanding: got %h", $realtime, got);
        fail_count++;
      end else begin
        want = averages_due.pop_front();
        if (want.alpha !== got.alpha || want.blue !== got.blue ||
            want.green !== got.green || want.red !== got.red) begin
          $display("%0t: average mismatch (a b g r): expected %h actual %h",
                   $realtime, want, got);
          fail_count++;
        end
      end
    end
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the area-average resampler: directed corner cases at the size
// extremes, then random phases that fill a small source image and mix target
// requests with further writes, under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 6000000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, cycles, sent;

  aair_in_if  px_in ();
  aair_out_if px_out ();

  area_average_image_resampler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (px_in.sink),
    .out_if (px_out.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  resample_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (px_in),
    .out_mon   (px_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk_i = 1'b0; #4;
    clk_i = 1'b1; #4;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("area_average_image_resampler_core test failed");
      $finish;
    end
  end

  // Result side: stretches of free flow, short stalls and the odd long one.
  int stall_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      px_out.ready = 1'b0;
    end else begin
      px_out.ready = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: stall_left = $urandom_range(1, 3);
        4:          stall_left = $urandom_range(20, 80);
        default:    ;
      endcase
    end
  end

  task automatic pause_random();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: n = $urandom_range(1, 3);
      5:             n = $urandom_range(20, 60);
      default:       n = 0;
    endcase
    if (n > 0) begin
      px_in.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_pixel(logic func, logic [7:0] x, logic [7:0] y, logic [31:0] argb);
    px_in.valid = 1'b1;
    px_in.func  = func;
    px_in.pos_x = x;
    px_in.pos_y = y;
    {px_in.in_alpha, px_in.in_blue, px_in.in_green, px_in.in_red} = argb;
    do @(posedge clk_i); while (!px_in.ready);
    @(negedge clk_i);
    sent++;
    pause_random();
  endtask

  task automatic write_size(logic [1:0] reg_idx, logic [aair_pkg::SzW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Only reprogram once the block has drained; a write request leaves nothing behind.
  task automatic set_sizes(logic [aair_pkg::SzW-1:0] sw, logic [aair_pkg::SzW-1:0] sh,
                           logic [aair_pkg::SzW-1:0] dw, logic [aair_pkg::SzW-1:0] dh);
    px_in.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    write_size(aair_pkg::RegSrcW, sw);
    write_size(aair_pkg::RegSrcH, sh);
    write_size(aair_pkg::RegDstW, dw);
    write_size(aair_pkg::RegDstH, dh);
  endtask

  int unsigned sw, sh, dw, dh;

  initial begin
    sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    px_in.valid = 1'b0; px_in.func = 1'b0; px_in.pos_x = '0; px_in.pos_y = '0;
    px_in.in_alpha = '0; px_in.in_blue = '0; px_in.in_green = '0; px_in.in_red = '0;
    px_out.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset sizes map one to one: each request reads exactly its own pixel.
    send_pixel(1'b0, 8'd0, 8'd0, 32'h0000_0000);
    send_pixel(1'b0, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_pixel(1'b0, 8'd128, 8'd77, 32'hA55A_3CC3);
    send_pixel(1'b1, 8'd0, 8'd0, $urandom());
    send_pixel(1'b1, 8'd255, 8'd255, $urandom());
    send_pixel(1'b1, 8'd128, 8'd77, $urandom());

    // Oversized width saturates, zero height reads as one row.
    set_sizes(9'd511, 9'd0, 9'd256, 9'd1);
    send_pixel(1'b0, 8'd255, 8'd0, 32'hFF00_FF00);
    send_pixel(1'b0, 8'd3, 8'd0, 32'h0102_8040);
    send_pixel(1'b1, 8'd255, 8'd200, 32'h0);
    send_pixel(1'b1, 8'd3, 8'd0, 32'h0);

    // All sizes zero: single pixel, any request clamps onto it.
    set_sizes(9'd0, 9'd0, 9'd0, 9'd0);
    send_pixel(1'b0, 8'd0, 8'd0, 32'h80FF_017F);
    send_pixel(1'b1, 8'd200, 8'd13, 32'h0);

    // 3x3 to 2x2: fractional overlaps.
    set_sizes(9'd3, 9'd3, 9'd2, 9'd2);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        send_pixel(1'b0, 8'(x), 8'(y), $urandom());
    for (int t = 0; t < 4; t++)
      send_pixel(1'b1, 8'(t % 2), 8'(t / 2), 32'h0);

    // Random phases: fill the whole source, then mix requests and writes.
    while (sent < 1650) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      dw = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16);
      dh = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16);
      set_sizes(9'(sw), 9'(sh), 9'(dw), 9'(dh));
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          send_pixel(1'b0, 8'(x), 8'(y), $urandom());
      repeat (110) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5:
            send_pixel(1'b1, 8'($urandom_range(0, 16)), 8'($urandom_range(0, 16)),
                       $urandom());
          6, 7, 8, 9, 10:
            send_pixel(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom());
          11, 12, 13, 14:
            send_pixel(1'b0, 8'($urandom_range(0, sw - 1)), 8'($urandom_range(0, sh - 1)),
                       $urandom());
          default:
            send_pixel(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom());
        endcase
      end
    end

    px_in.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (fail_count == 0)
      $display("area_average_image_resampler_core test passed");
    else
      $display("area_average_image_resampler_core test failed");
    $finish;
  end

endmodule
